@@ sv/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, fixed-point constants and the CORDIC angle table for the
// quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

	// quaternion component width (Q30)
	localparam int QW = 32;
	// doubled pairwise product, floor(a*b / 2^29)
	localparam int PW = 35;
	// sums of products
	localparam int TW = 37;
	// CORDIC datapath width
	localparam int CW = 40;
	// angle accumulator width (Q16 degrees)
	localparam int AW = 26;
	// magnitude multiplier split point
	localparam int LOW_BITS = 20;
	// inverse CORDIC gain width
	localparam int KW = 24;

	localparam logic signed [TW-1:0] ONE_Q30  = TW'(64'sd1 << 30);
	localparam logic signed [AW-1:0] DEG90    = AW'(90 << 16);
	localparam logic signed [AW-1:0] DEG180   = AW'(180 << 16);
	localparam logic [KW-1:0]        INVK_Q24 = KW'(10188014);

	// atan(2^-i) in Q16 degrees, rounded to nearest
	function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] idx);
		logic signed [AW-1:0] v;
		case (idx)
			5'd0:    v = AW'(2949120);
			5'd1:    v = AW'(1740967);
			5'd2:    v = AW'(919879);
			5'd3:    v = AW'(466945);
			5'd4:    v = AW'(234379);
			5'd5:    v = AW'(117304);
			5'd6:    v = AW'(58666);
			5'd7:    v = AW'(29335);
			5'd8:    v = AW'(14668);
			5'd9:    v = AW'(7334);
			5'd10:   v = AW'(3667);
			5'd11:   v = AW'(1833);
			5'd12:   v = AW'(917);
			5'd13:   v = AW'(458);
			5'd14:   v = AW'(229);
			5'd15:   v = AW'(115);
			5'd16:   v = AW'(57);
			5'd17:   v = AW'(29);
			5'd18:   v = AW'(14);
			5'd19:   v = AW'(7);
			5'd20:   v = AW'(4);
			5'd21:   v = AW'(2);
			5'd22:   v = AW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/q2e_delay.sv @@
// ----------------------------------------------------------------------------
// q2e_delay
// Fixed-length register chain that carries side data alongside a pipeline.
// ----------------------------------------------------------------------------
module q2e_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	// shift side data one stage per cycle
	always_ff @(posedge clk) begin
		tap_s[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

@@ sv/q2e_cordic.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC: Q16 degree atan2(y, x) and the gain-scaled
// magnitude. One quadrant pre-rotation stage, then one stage per iteration.
// ----------------------------------------------------------------------------
module q2e_cordic #(
	parameter int STAGES = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic signed [q2e_pkg::CW-1:0]    in_y,
	input  logic signed [q2e_pkg::CW-1:0]    in_x,
	output logic                             out_vld,
	output logic signed [q2e_pkg::AW-1:0]    out_ang,
	output logic signed [q2e_pkg::CW-1:0]    out_x
);

	logic                          vld_s  [STAGES+1];
	logic                          zero_s [STAGES+1];
	logic signed [q2e_pkg::CW-1:0] x_s    [STAGES+1];
	logic signed [q2e_pkg::CW-1:0] y_s    [STAGES+1];
	logic signed [q2e_pkg::AW-1:0] ang_s  [STAGES+1];
	logic signed [q2e_pkg::AW-1:0] ang_end;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_vld;
			for (int i = 1; i <= STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// pre-rotate left half plane by +-90 degrees, flag the zero vector
	always_ff @(posedge clk) begin
		zero_s[0] <= (in_x == '0) && (in_y == '0);
		if (in_x < 0) begin
			if (in_y >= 0) begin
				x_s[0]   <= in_y;
				y_s[0]   <= -in_x;
				ang_s[0] <= q2e_pkg::DEG90;
			end else begin
				x_s[0]   <= -in_y;
				y_s[0]   <= in_x;
				ang_s[0] <= -q2e_pkg::DEG90;
			end
		end else begin
			x_s[0]   <= in_x;
			y_s[0]   <= in_y;
			ang_s[0] <= '0;
		end
	end

	// one micro-rotation per stage
	for (genvar g = 0; g < STAGES; g++) begin : g_iter
		localparam logic signed [q2e_pkg::AW-1:0] TAB = q2e_pkg::atan_q16(5'(g));
		always_ff @(posedge clk) begin
			zero_s[g+1] <= zero_s[g];
			if (y_s[g] >= 0) begin
				x_s[g+1]   <= x_s[g] + (y_s[g] >>> g);
				y_s[g+1]   <= y_s[g] - (x_s[g] >>> g);
				ang_s[g+1] <= ang_s[g] + TAB;
			end else begin
				x_s[g+1]   <= x_s[g] - (y_s[g] >>> g);
				y_s[g+1]   <= y_s[g] + (x_s[g] >>> g);
				ang_s[g+1] <= ang_s[g] - TAB;
			end
		end
	end

	// saturate the angle to +-180
	always_comb begin
		if (ang_s[STAGES] > q2e_pkg::DEG180) begin
			ang_end = q2e_pkg::DEG180;
		end else if (ang_s[STAGES] < -q2e_pkg::DEG180) begin
			ang_end = -q2e_pkg::DEG180;
		end else begin
			ang_end = ang_s[STAGES];
		end
	end

	assign out_vld = vld_s[STAGES];
	assign out_ang = zero_s[STAGES] ? '0 : ang_end;
	assign out_x   = zero_s[STAGES] ? '0 : x_s[STAGES];

endmodule

@@ sv/quaternion_to_euler_angles_core.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Converts a Q30 attitude quaternion into pitch, roll and yaw in Q16 degrees
// using pipelined CORDIC arctangents.
// ----------------------------------------------------------------------------
// Usage:
//   Drive quat_w/x/y/z and pulse start; an item is taken on every clock edge
//   with start high and busy low. busy is always low, so an item may enter
//   in every cycle: throughput is one item per clock.
//   Each item produces one result on pitch_deg, roll_deg and yaw_deg, marked
//   by done for exactly one cycle. Results leave in order of entry.
//   From the accepting edge to done, an item passes the product stage, the
//   sum stage, the yaw and roll CORDIC, the partial-product and magnitude
//   registers, the pitch CORDIC and one output register. The two CORDIC
//   pipelines lie chained on this path.
//   The receiver cannot hold results off; there is no back pressure.
//   arst_n clears all valid bits, so nothing in flight survives reset and
//   done stays low until new items arrive.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	output logic               done,
	output logic signed [24:0] pitch_deg,
	output logic signed [23:0] roll_deg,
	output logic signed [24:0] yaw_deg
);

	localparam int PW = q2e_pkg::PW;
	localparam int TW = q2e_pkg::TW;
	localparam int CW = q2e_pkg::CW;
	localparam int AW = q2e_pkg::AW;
	localparam int LB = q2e_pkg::LOW_BITS;
	localparam int KW = q2e_pkg::KW;
	localparam int HB = CW - 1 - LB;

	logic signed [63:0] m_ww, m_wx, m_wy, m_wz, m_xy, m_xz, m_yy, m_yz, m_zz;

	logic                 vld_s1, vld_s2, vld_m1, vld_m2;
	logic signed [PW-1:0] ww_s1, wx_s1, wy_s1, wz_s1, xy_s1, xz_s1, yy_s1, yz_s1, zz_s1;
	logic signed [TW-1:0] t1_s2, t2_s2, t3_s2, c_s2, r_s2;

	logic                 yaw_vld;
	logic signed [AW-1:0] yaw_ang, roll_ang;
	logic signed [CW-1:0] yaw_x;
	logic [CW-2:0]        mx_pos;

	logic [LB+KW-1:0]     plo_m1;
	logic [HB+KW-1:0]     phi_m1;
	logic [63:0]          msum;
	logic signed [CW-1:0] mag_m2;

	logic [TW:0]          side1;
	logic [TW+2*AW:0]     side2_in, side2;
	logic [2*AW:0]        side3_in, side3;
	logic signed [TW-1:0] t3_d;

	logic                 pit_vld;
	logic signed [AW-1:0] pit_ang;
	logic signed [CW-1:0] pit_x;

	logic                 c_neg;
	logic signed [AW-1:0] yaw_f, roll_f;
	logic signed [AW:0]   pit_v, roll_v, yaw_v;

	assign busy = 1'b0;

	// pairwise products, full 64-bit
	assign m_ww = quat_w * quat_w;
	assign m_wx = quat_w * quat_x;
	assign m_wy = quat_w * quat_y;
	assign m_wz = quat_w * quat_z;
	assign m_xy = quat_x * quat_y;
	assign m_xz = quat_x * quat_z;
	assign m_yy = quat_y * quat_y;
	assign m_yz = quat_y * quat_z;
	assign m_zz = quat_z * quat_z;

	// advance valid bits of the front and magnitude stages, register done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_m1 <= yaw_vld;
			vld_m2 <= vld_m1;
			done   <= pit_vld;
		end
	end

	// stage 1: doubled products, floor of divide by 2^29
	always_ff @(posedge clk) begin
		ww_s1 <= m_ww[63:29];
		wx_s1 <= m_wx[63:29];
		wy_s1 <= m_wy[63:29];
		wz_s1 <= m_wz[63:29];
		xy_s1 <= m_xy[63:29];
		xz_s1 <= m_xz[63:29];
		yy_s1 <= m_yy[63:29];
		yz_s1 <= m_yz[63:29];
		zz_s1 <= m_zz[63:29];
	end

	// stage 2: rotation matrix terms
	always_ff @(posedge clk) begin
		t1_s2 <= TW'(xy_s1) - TW'(wz_s1);
		t2_s2 <= TW'(yy_s1) + TW'(ww_s1) - q2e_pkg::ONE_Q30;
		t3_s2 <= TW'(yz_s1) + TW'(wx_s1);
		c_s2  <= TW'(zz_s1) + TW'(ww_s1) - q2e_pkg::ONE_Q30;
		r_s2  <= TW'(xz_s1) - TW'(wy_s1);
	end

	// yaw and roll arctangents
	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s2),
		.in_y   (CW'(t1_s2)),
		.in_x   (CW'(t2_s2)),
		.out_vld(yaw_vld),
		.out_ang(yaw_ang),
		.out_x  (yaw_x)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s2),
		.in_y   (CW'(c_s2)),
		.in_x   (CW'(r_s2)),
		.out_vld(),
		.out_ang(roll_ang),
		.out_x  ()
	);

	// hold t3 and the sign of c beside the first CORDIC
	q2e_delay #(.WIDTH(TW+1), .DEPTH(CORDIC_STAGES+1)) u_side1 (
		.clk (clk),
		.din ({t3_s2, c_s2[TW-1]}),
		.dout(side1)
	);

	// magnitude: clamp negative, scale by inverse gain in two partial products
	assign mx_pos = yaw_x[CW-1] ? '0 : yaw_x[CW-2:0];

	always_ff @(posedge clk) begin
		plo_m1 <= (LB+KW)'(mx_pos[LB-1:0]) * (LB+KW)'(q2e_pkg::INVK_Q24);
		phi_m1 <= (HB+KW)'(mx_pos[CW-2:LB]) * (HB+KW)'(q2e_pkg::INVK_Q24);
	end

	assign msum = (64'(phi_m1) << LB) + 64'(plo_m1);

	always_ff @(posedge clk) begin
		mag_m2 <= msum[KW+CW-1:KW];
	end

	assign side2_in = {side1, yaw_ang, roll_ang};

	q2e_delay #(.WIDTH(TW+2*AW+1), .DEPTH(2)) u_side2 (
		.clk (clk),
		.din (side2_in),
		.dout(side2)
	);

	assign t3_d = side2[TW+2*AW:2*AW+1];

	// pitch arctangent
	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_m2),
		.in_y   (CW'(t3_d)),
		.in_x   (mag_m2),
		.out_vld(pit_vld),
		.out_ang(pit_ang),
		.out_x  (pit_x)
	);

	assign side3_in = side2[2*AW:0];

	q2e_delay #(.WIDTH(2*AW+1), .DEPTH(CORDIC_STAGES+1)) u_side3 (
		.clk (clk),
		.din (side3_in),
		.dout(side3)
	);

	assign c_neg  = side3[2*AW];
	assign yaw_f  = side3[2*AW-1:AW];
	assign roll_f = side3[AW-1:0];

	// fold pitch and roll, negate yaw, saturate pitch and roll to field ranges
	always_comb begin
		pit_v = (AW+1)'(pit_ang);
		if (c_neg) begin
			if (pit_ang >= 0) begin
				pit_v = (AW+1)'(q2e_pkg::DEG180) - (AW+1)'(pit_ang);
			end else begin
				pit_v = -(AW+1)'(q2e_pkg::DEG180) - (AW+1)'(pit_ang);
			end
		end
		if (pit_v > (AW+1)'(q2e_pkg::DEG180)) begin
			pit_v = (AW+1)'(q2e_pkg::DEG180);
		end else if (pit_v < -(AW+1)'(q2e_pkg::DEG180)) begin
			pit_v = -(AW+1)'(q2e_pkg::DEG180);
		end

		roll_v = (AW+1)'(roll_f) - (AW+1)'(q2e_pkg::DEG90);
		if (roll_v >= (AW+1)'(q2e_pkg::DEG90)) begin
			roll_v = (AW+1)'(q2e_pkg::DEG180) - roll_v;
		end
		if (roll_v < -(AW+1)'(q2e_pkg::DEG90)) begin
			roll_v = -(AW+1)'(q2e_pkg::DEG180) - roll_v;
		end
		if (roll_v > (AW+1)'(q2e_pkg::DEG90)) begin
			roll_v = (AW+1)'(q2e_pkg::DEG90);
		end else if (roll_v < -(AW+1)'(q2e_pkg::DEG90)) begin
			roll_v = -(AW+1)'(q2e_pkg::DEG90);
		end

		yaw_v = -(AW+1)'(yaw_f);
	end

	// output register; pitch magnitude output of the last CORDIC is unused
	always_ff @(posedge clk) begin
		pitch_deg <= pit_v[24:0] | 25'(pit_x & '0);
		roll_deg  <= roll_v[23:0];
		yaw_deg   <= yaw_v[24:0];
	end

endmodule

@@ tb/quaternion_to_euler_angles_core_test.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core_test
// Self-checking bench for the quaternion to Euler angle converter. A queue of
// quaternions feeds a clocked driver. Each accepted item is predicted with a
// 64-bit CORDIC model. A clocked monitor compares every done strobe with the
// oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     STAGES   = 24;
	localparam longint Q30_ONE  = 64'sd1 << 30;
	localparam longint ANG_90   = 64'sd90 << 16;
	localparam longint ANG_180  = 64'sd180 << 16;
	localparam longint INV_GAIN = 64'sd10188014;
	localparam int     HALF_RT2 = 759250125;	// 0.7071 in Q30

	typedef struct {
		logic signed [31:0] w, x, y, z;
		int                 idle_pct;	// chance of holding start low per cycle
		bit                 drain;	// wait for an empty pipe before sending
	} quat_item_t;

	typedef struct {
		logic signed [24:0] pitch;
		logic signed [23:0] roll;
		logic signed [24:0] yaw;
	} euler_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic               done;
	logic signed [24:0] pitch_deg;
	logic signed [23:0] roll_deg;
	logic signed [24:0] yaw_deg;

	quat_item_t pending_quats[$];
	euler_t     expected_angles[$];
	quat_item_t on_port;
	bit         taken;
	int         mismatches = 0;

	longint atan_step[STAGES] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
		2, 1, 0};

	quaternion_to_euler_angles_core #(.CORDIC_STAGES(STAGES)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.done(done), .pitch_deg(pitch_deg), .roll_deg(roll_deg), .yaw_deg(yaw_deg)
	);

	// free-running clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// vectoring CORDIC: Q16 degree angle of (xv, yv), final x in mag_x
	function automatic longint vec_angle(longint yv, longint xv, output longint mag_x);
		longint ang, nx, ny;
		ang = 0;
		if (xv == 0 && yv == 0) begin
			mag_x = 0;
			return 0;
		end
		if (xv < 0) begin
			if (yv >= 0) begin
				nx = yv; ny = -xv; ang = ANG_90;
			end else begin
				nx = -yv; ny = xv; ang = -ANG_90;
			end
			xv = nx; yv = ny;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (yv >= 0) begin
				nx = xv + (yv >>> i); ny = yv - (xv >>> i); ang += atan_step[i];
			end else begin
				nx = xv - (yv >>> i); ny = yv + (xv >>> i); ang -= atan_step[i];
			end
			xv = nx; yv = ny;
		end
		mag_x = xv;
		return clamp(ang, ANG_180);
	endfunction

	function automatic euler_t predict_angles(quat_item_t q);
		longint w, x, y, z, ww, wx, wy, wz, xy, xz, yy, yz, zz;
		longint t1, t2, t3, c, r, mx, unused, mag, yaw, pitch, roll;
		euler_t e;
		w = q.w; x = q.x; y = q.y; z = q.z;
		// doubled products in Q30, floor division
		ww = (w * w) >>> 29; wx = (w * x) >>> 29; wy = (w * y) >>> 29;
		wz = (w * z) >>> 29; xy = (x * y) >>> 29; xz = (x * z) >>> 29;
		yy = (y * y) >>> 29; yz = (y * z) >>> 29; zz = (z * z) >>> 29;
		t1 = xy - wz;
		t2 = yy + ww - Q30_ONE;
		t3 = yz + wx;
		c  = zz + ww - Q30_ONE;
		r  = xz - wy;
		yaw = -vec_angle(t1, t2, mx);
		if (mx < 0) mx = 0;
		mag = (mx * INV_GAIN) >>> 24;
		pitch = vec_angle(t3, mag, unused);
		// reflect toward +-180 when the body is upside down
		if (c < 0) pitch = (pitch >= 0) ? ANG_180 - pitch : -ANG_180 - pitch;
		roll = vec_angle(c, r, unused) - ANG_90;
		if (roll >= ANG_90) roll = ANG_180 - roll;
		if (roll < -ANG_90) roll = -ANG_180 - roll;
		e.pitch = 25'(clamp(pitch, ANG_180));
		e.roll  = 24'(clamp(roll, ANG_90));
		e.yaw   = 25'(clamp(yaw, ANG_180));
		return e;
	endfunction

	task automatic report(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic quat_item_t make_quat(int w, int x, int y, int z, int idle, bit drain);
		quat_item_t q;
		q.w = w; q.x = x; q.y = y; q.z = z; q.idle_pct = idle; q.drain = drain;
		return q;
	endfunction

	function automatic int corner_value();
		case ($urandom_range(5))
			0: return 1 << 30;
			1: return -(1 << 30);
			2: return 32'h7fffffff;
			3: return 32'h80000000;
			4: return 0;
			default: return HALF_RT2;
		endcase
	endfunction

	// random item: mostly unit quaternions, the rest raw patterns, corners and small values
	function automatic quat_item_t random_quat(int idle);
		real a[4];
		real n;
		int c[4];
		int kind;
		kind = $urandom_range(99);
		if (kind < 70) begin
			do begin
				n = 0.0;
				for (int i = 0; i < 4; i++) begin
					a[i] = (real'($urandom_range(2000000)) - 1000000.0) / 1000000.0;
					// push some items toward gimbal lock
					if (kind < 10 && i >= 2) a[i] = a[i] * 0.001;
					n += a[i] * a[i];
				end
			end while (n < 1.0e-6);
			n = $sqrt(n);
			for (int i = 0; i < 4; i++) c[i] = $rtoi(a[i] / n * 1073741824.0);
		end else if (kind < 82) begin
			for (int i = 0; i < 4; i++) c[i] = $urandom;
		end else if (kind < 92) begin
			for (int i = 0; i < 4; i++) c[i] = corner_value();
		end else begin
			for (int i = 0; i < 4; i++) c[i] = $urandom_range(2000) - 1000;
		end
		return make_quat(c[0], c[1], c[2], c[3], idle, 1'b0);
	endfunction

	// driver: present queued items, hold an item until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) expected_angles.push_back(predict_angles(on_port));
			if (start && !taken) begin
				// hold the current item
			end else if (pending_quats.size() > 0
					&& !(pending_quats[0].drain && (taken || expected_angles.size() > 0))
					&& $urandom_range(99) >= pending_quats[0].idle_pct) begin
				on_port = pending_quats.pop_front();
				start  <= 1'b1;
				quat_w <= on_port.w;
				quat_x <= on_port.x;
				quat_y <= on_port.y;
				quat_z <= on_port.z;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_angles.size() == 0) begin
				report("unexpected result", pitch_deg, 0);
			end else begin
				euler_t e;
				e = expected_angles.pop_front();
				if (pitch_deg !== e.pitch) report("pitch_deg", pitch_deg, e.pitch);
				if (roll_deg !== e.roll) report("roll_deg", roll_deg, e.roll);
				if (yaw_deg !== e.yaw) report("yaw_deg", yaw_deg, e.yaw);
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int phase_idle[4] = '{0, 60, 11, 0};
		// directed: identity, axis flips, zero, word extremes, quarter turns, gimbal lock
		pending_quats.push_back(make_quat(1 << 30, 0, 0, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(-(1 << 30), 0, 0, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(0, 1 << 30, 0, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(0, -(1 << 30), 0, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(0, 0, 1 << 30, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(0, 0, -(1 << 30), 0, 0, 1'b0));
		pending_quats.push_back(make_quat(0, 0, 0, 1 << 30, 0, 1'b0));
		pending_quats.push_back(make_quat(0, 0, 0, -(1 << 30), 0, 1'b0));
		pending_quats.push_back(make_quat(0, 0, 0, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 0, 1'b0));
		pending_quats.push_back(make_quat(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 0, 1'b0));
		pending_quats.push_back(make_quat(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 0, 1'b0));
		pending_quats.push_back(make_quat(1 << 29, 1 << 29, 1 << 29, 1 << 29, 0, 1'b0));
		pending_quats.push_back(make_quat(1 << 29, -(1 << 29), 1 << 29, -(1 << 29), 0, 1'b0));
		pending_quats.push_back(make_quat(HALF_RT2, HALF_RT2, 0, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(HALF_RT2, -HALF_RT2, 0, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(HALF_RT2, 0, HALF_RT2, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(HALF_RT2, 0, -HALF_RT2, 0, 0, 1'b0));
		pending_quats.push_back(make_quat(HALF_RT2, 0, 0, HALF_RT2, 0, 1'b0));
		pending_quats.push_back(make_quat(HALF_RT2, 0, 0, -HALF_RT2, 0, 1'b0));
		pending_quats.push_back(make_quat(0, HALF_RT2, 0, HALF_RT2, 0, 1'b0));
		pending_quats.push_back(make_quat(0, 0, HALF_RT2, -HALF_RT2, 0, 1'b0));
		// random phases, each opening on an empty pipe
		foreach (phase_idle[p]) begin
			for (int i = 0; i < 500; i++) begin
				quat_item_t q;
				q = random_quat(phase_idle[p]);
				q.drain = (i == 0);
				pending_quats.push_back(q);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(posedge clk);
		while (pending_quats.size() > 0 || start || expected_angles.size() > 0);
		repeat (2 * STAGES + 12) @(posedge clk);
		if (mismatches == 0 && expected_angles.size() == 0)
			$display("quaternion_to_euler_angles_core regression: pass");
		else
			$display("quaternion_to_euler_angles_core regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("quaternion_to_euler_angles_core regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/q2e_pkg.sv
sv/q2e_delay.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_angles_core.sv
tb/quaternion_to_euler_angles_core_test.sv
